FILE: rtl/psla_pkg.sv
// ----------------------------------------------------------------------------
// psla_pkg
// Shared types and constants of the proportional share lock arbiter: table
// geometry, field widths, status and function codes, sequencer states.
// ----------------------------------------------------------------------------
package psla_pkg;

  localparam int MAX_THREADS = 16;
  localparam int SLOT_W      = $clog2(MAX_THREADS);
  localparam int CNT_W       = $clog2(MAX_THREADS + 1);
  localparam int TID_W       = 22;
  localparam int TS_W        = 64;
  localparam int ADDR_W      = 4;

  localparam logic [TS_W-1:0]   DEFAULT_IDLE_LIMIT = 64'd2400000000;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_THREADS - 1);

  // register index, taken from paddr[3]
  localparam logic REG_IDLE_LIMIT = 1'b0;

  localparam logic FUNC_ACQUIRE = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_BANNED   = 3'd1,
    ST_BUSY     = 3'd2,
    ST_FULL     = 3'd3,
    ST_RELEASED = 3'd4,
    ST_NOT_HELD = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_REL_CALC,
    S_REL_MUL,
    S_REL_WRITE,
    S_EVICT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [TID_W-1:0] tid;
    logic [TS_W-1:0]  ban_deadline;
    logic [TS_W-1:0]  start_time;
    logic [TS_W-1:0]  end_time;
  } entry_t;

endpackage

FILE: rtl/proportional_share_lock_arbiter_unit.sv
// ----------------------------------------------------------------------------
// proportional_share_lock_arbiter_unit
// Lock arbiter with a per-thread ban table held in one synchronous memory.
// ----------------------------------------------------------------------------
// Usage
//   Request channel (in_valid / in_stall): func, thread_id, now. One request
//   is worked on at a time; in_stall is low only while the sequencer is idle.
//   Reply channel (out_valid / out_stall): status, retry_at, active_threads,
//   evicted_count, one reply per request, held in an output register so a
//   new request may be taken while an old reply still waits.
//   An acquire while the lock is held and a release while it is not held go
//   straight to the reply; an acquire walks the slots until the thread is
//   found, to the last slot for a new thread; a release passes the calculate,
//   multiply and write-back states, then the eviction walk when it runs.
//   The table walks read one slot per cycle through the single read port of
//   the slot memory; the release with its eviction walk sets the worst case.
//   A stalled reply holds the sequencer in its reply state until taken.
//   Reset (rst, synchronous) clears the valid bits, the lock, the active count
//   and the reply valid bit and loads the default idle threshold; slot contents
//   are only read after they are written, so the memory needs no clearing.
//   The APB port holds the idle threshold at address 0 (64-bit data).
// ----------------------------------------------------------------------------
module proportional_share_lock_arbiter_unit (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          func,
  input  logic [psla_pkg::TID_W-1:0]    thread_id,
  input  logic [psla_pkg::TS_W-1:0]     now,
  // reply channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    status,
  output logic [psla_pkg::TS_W-1:0]     retry_at,
  output logic [psla_pkg::CNT_W-1:0]    active_threads,
  output logic [psla_pkg::CNT_W-1:0]    evicted_count,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psla_pkg::ADDR_W-1:0]   paddr,
  input  logic [psla_pkg::TS_W-1:0]     pwdata,
  output logic [psla_pkg::TS_W-1:0]     prdata,
  output logic                          pready
);

  localparam int SLOT_W = psla_pkg::SLOT_W;
  localparam int CNT_W  = psla_pkg::CNT_W;
  localparam int TID_W  = psla_pkg::TID_W;
  localparam int TS_W   = psla_pkg::TS_W;

  // slot memory
  psla_pkg::entry_t mem [psla_pkg::MAX_THREADS];
  psla_pkg::entry_t mem_rdata;
  psla_pkg::entry_t mem_wdata;
  logic [SLOT_W-1:0] mem_raddr, mem_waddr;
  logic              mem_we;

  // control state
  psla_pkg::state_t state, state_next;
  logic [psla_pkg::MAX_THREADS-1:0] slot_valid, slot_valid_next;
  logic              lock_held, lock_held_next;
  logic [SLOT_W-1:0] holder_slot, holder_slot_next;
  logic [CNT_W-1:0]  active_count, active_count_next;
  logic              scan_live, scan_live_next;
  logic              out_valid_next;

  // payload registers
  logic [TID_W-1:0]  req_tid, req_tid_next;
  logic [TS_W-1:0]   req_now, req_now_next;
  logic [SLOT_W-1:0] scan_idx, scan_idx_next;
  logic [SLOT_W-1:0] rd_slot, rd_slot_next;
  psla_pkg::entry_t  ent, ent_next;
  logic [TS_W-1:0]   cs, cs_next;
  logic [TS_W-1:0]   limit, limit_next;
  logic              evict_go, evict_go_next;
  logic [TS_W-1:0]   prod, prod_next;
  psla_pkg::status_t res_status, res_status_next;
  logic [TS_W-1:0]   res_retry, res_retry_next;
  logic [CNT_W-1:0]  res_evicted, res_evicted_next;
  psla_pkg::status_t out_status, out_status_next;
  logic [TS_W-1:0]   out_retry, out_retry_next;
  logic [CNT_W-1:0]  out_active, out_active_next;
  logic [CNT_W-1:0]  out_evicted, out_evicted_next;

  logic [TS_W-1:0]   thr;

  // datapath helpers
  logic              hit, banned, free_found;
  logic [SLOT_W-1:0] free_slot;
  logic [TS_W+CNT_W-1:0] mul_full;
  logic [TS_W:0]     ban_sum;
  logic [TS_W-1:0]   ban_new;
  logic              cfg_wr;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[3] == psla_pkg::REG_IDLE_LIMIT) ? thr : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= psla_pkg::DEFAULT_IDLE_LIMIT;
    end else if (cfg_wr && paddr[3] == psla_pkg::REG_IDLE_LIMIT) begin
      thr <= pwdata;
    end
  end

  // --------------------------------------------------------------------------
  // slot memory, one write and one registered read per cycle
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  // --------------------------------------------------------------------------
  // datapath helpers
  // --------------------------------------------------------------------------
  assign hit    = scan_live && slot_valid[rd_slot] && (mem_rdata.tid == req_tid);
  assign banned = (mem_rdata.end_time < mem_rdata.ban_deadline) &&
                  (req_now < mem_rdata.ban_deadline);

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = psla_pkg::MAX_THREADS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end
  end

  assign mul_full = {{CNT_W{1'b0}}, cs} * {{TS_W{1'b0}}, active_count};
  assign ban_sum  = {1'b0, ent.ban_deadline} + {1'b0, prod};
  assign ban_new  = (active_count > CNT_W'(1)) ?
                    (ban_sum[TS_W] ? '1 : ban_sum[TS_W-1:0]) : req_now;

  // --------------------------------------------------------------------------
  // sequencer: next state and outputs
  // --------------------------------------------------------------------------
  always_comb begin
    state_next        = state;
    slot_valid_next   = slot_valid;
    lock_held_next    = lock_held;
    holder_slot_next  = holder_slot;
    active_count_next = active_count;
    scan_live_next    = scan_live;
    scan_idx_next     = scan_idx;
    rd_slot_next      = rd_slot;
    req_tid_next      = req_tid;
    req_now_next      = req_now;
    ent_next          = ent;
    cs_next           = cs;
    limit_next        = limit;
    evict_go_next     = evict_go;
    prod_next         = prod;
    res_status_next   = res_status;
    res_retry_next    = res_retry;
    res_evicted_next  = res_evicted;
    out_valid_next    = out_valid && out_stall;
    out_status_next   = out_status;
    out_retry_next    = out_retry;
    out_active_next   = out_active;
    out_evicted_next  = out_evicted;
    mem_raddr         = scan_idx;
    mem_we            = 1'b0;
    mem_waddr         = rd_slot;
    mem_wdata         = mem_rdata;
    in_stall          = (state != psla_pkg::S_IDLE);

    unique case (state)
      psla_pkg::S_IDLE: begin
        // holder entry is read ahead for a release
        mem_raddr = holder_slot;
        if (in_valid) begin
          req_tid_next     = thread_id;
          req_now_next     = now;
          res_retry_next   = '0;
          res_evicted_next = '0;
          scan_idx_next    = '0;
          scan_live_next   = 1'b0;
          if (func == psla_pkg::FUNC_ACQUIRE) begin
            if (lock_held) begin
              res_status_next = psla_pkg::ST_BUSY;
              state_next      = psla_pkg::S_RESP;
            end else begin
              state_next = psla_pkg::S_SCAN;
            end
          end else begin
            if (!lock_held) begin
              res_status_next = psla_pkg::ST_NOT_HELD;
              state_next      = psla_pkg::S_RESP;
            end else begin
              state_next = psla_pkg::S_REL_CALC;
            end
          end
        end
      end

      psla_pkg::S_SCAN: begin
        mem_raddr      = scan_idx;
        scan_idx_next  = scan_idx + SLOT_W'(1);
        scan_live_next = 1'b1;
        rd_slot_next   = scan_idx;
        if (hit) begin
          if (banned) begin
            res_status_next = psla_pkg::ST_BANNED;
            res_retry_next  = mem_rdata.ban_deadline;
          end else begin
            mem_we               = 1'b1;
            mem_waddr            = rd_slot;
            mem_wdata            = mem_rdata;
            mem_wdata.start_time = req_now;
            lock_held_next       = 1'b1;
            holder_slot_next     = rd_slot;
            res_status_next      = psla_pkg::ST_GRANTED;
          end
          state_next = psla_pkg::S_RESP;
        end else if (scan_live && rd_slot == psla_pkg::LAST_SLOT) begin
          if (free_found) begin
            mem_we                     = 1'b1;
            mem_waddr                  = free_slot;
            mem_wdata.tid              = req_tid;
            mem_wdata.ban_deadline     = req_now;
            mem_wdata.start_time       = req_now;
            mem_wdata.end_time         = req_now;
            slot_valid_next[free_slot] = 1'b1;
            active_count_next          = active_count + CNT_W'(1);
            lock_held_next             = 1'b1;
            holder_slot_next           = free_slot;
            res_status_next            = psla_pkg::ST_GRANTED;
          end else begin
            res_status_next = psla_pkg::ST_FULL;
          end
          state_next = psla_pkg::S_RESP;
        end
      end

      psla_pkg::S_REL_CALC: begin
        ent_next      = mem_rdata;
        cs_next       = (req_now >= mem_rdata.start_time) ?
                        req_now - mem_rdata.start_time : '0;
        limit_next    = req_now - thr;
        evict_go_next = (active_count > CNT_W'(1)) && (req_now >= thr);
        state_next    = psla_pkg::S_REL_MUL;
      end

      psla_pkg::S_REL_MUL: begin
        prod_next  = (|mul_full[TS_W+CNT_W-1:TS_W]) ? '1 : mul_full[TS_W-1:0];
        state_next = psla_pkg::S_REL_WRITE;
      end

      psla_pkg::S_REL_WRITE: begin
        mem_we                 = 1'b1;
        mem_waddr              = holder_slot;
        mem_wdata              = ent;
        mem_wdata.ban_deadline = ban_new;
        mem_wdata.end_time     = req_now;
        lock_held_next         = 1'b0;
        res_status_next        = psla_pkg::ST_RELEASED;
        state_next             = evict_go ? psla_pkg::S_EVICT : psla_pkg::S_RESP;
      end

      psla_pkg::S_EVICT: begin
        // holder write-back landed before the first walk read
        mem_raddr      = scan_idx;
        scan_idx_next  = scan_idx + SLOT_W'(1);
        scan_live_next = 1'b1;
        rd_slot_next   = scan_idx;
        if (scan_live) begin
          if (rd_slot != holder_slot && slot_valid[rd_slot] &&
              mem_rdata.end_time < limit) begin
            slot_valid_next[rd_slot] = 1'b0;
            active_count_next        = active_count - CNT_W'(1);
            res_evicted_next         = res_evicted + CNT_W'(1);
          end
          if (rd_slot == psla_pkg::LAST_SLOT) begin
            state_next = psla_pkg::S_RESP;
          end
        end
      end

      psla_pkg::S_RESP: begin
        if (!out_valid || !out_stall) begin
          out_valid_next   = 1'b1;
          out_status_next  = res_status;
          out_retry_next   = res_retry;
          out_active_next  = active_count;
          out_evicted_next = res_evicted;
          state_next       = psla_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = psla_pkg::S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= psla_pkg::S_IDLE;
      slot_valid   <= '0;
      lock_held    <= 1'b0;
      holder_slot  <= '0;
      active_count <= '0;
      scan_live    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      slot_valid   <= slot_valid_next;
      lock_held    <= lock_held_next;
      holder_slot  <= holder_slot_next;
      active_count <= active_count_next;
      scan_live    <= scan_live_next;
      out_valid    <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    req_tid     <= req_tid_next;
    req_now     <= req_now_next;
    scan_idx    <= scan_idx_next;
    rd_slot     <= rd_slot_next;
    ent         <= ent_next;
    cs          <= cs_next;
    limit       <= limit_next;
    evict_go    <= evict_go_next;
    prod        <= prod_next;
    res_status  <= res_status_next;
    res_retry   <= res_retry_next;
    res_evicted <= res_evicted_next;
    out_status  <= out_status_next;
    out_retry   <= out_retry_next;
    out_active  <= out_active_next;
    out_evicted <= out_evicted_next;
  end

  assign status         = out_status;
  assign retry_at       = out_retry;
  assign active_threads = out_active;
  assign evicted_count  = out_evicted;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    active_count == CNT_W'($countones(slot_valid)))
    else $error("active count differs from number of valid slots");

  a_holder_valid: assert property (@(posedge clk) disable iff (rst)
    lock_held |-> slot_valid[holder_slot])
    else $error("lock held by an invalid slot");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state != psla_pkg::S_IDLE))
    else $error("accepted transaction did not start the sequencer");

  a_release_clears_lock: assert property (@(posedge clk) disable iff (rst)
    (state == psla_pkg::S_REL_WRITE) |=> !lock_held)
    else $error("release write-back left the lock held");

endmodule
